[sv/jvpm_pkg.sv]
// Shared constants, command and status types, and channel tables for the valve duty mapper.
package jvpm_pkg;

   localparam int NUM_CH   = 21;
   localparam int CH_W     = 5;
   localparam int DUTY_W   = 7;
   localparam int STICK_W  = 8;
   localparam int CFG_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 16;
   localparam int NUM_AXES = 4;
   localparam int AXIS_IDX_W = 2;

   localparam logic [STICK_W-1:0] STICK_MID = 8'd127;
   localparam logic [DUTY_W-1:0]  FULL_PCT  = 7'd100;
   localparam logic [CH_W-1:0]    LAST_IDX  = 5'd20;
   localparam logic [AXIS_IDX_W-1:0] LAST_AXIS = 2'd3;

   // Percentage of a deflection: floor(a * 100 / 127) is taken as
   // (a * 100 * 516) >> 16, which is exact or one low, and then corrected.
   localparam logic [15:0] PCT_SCALE = 16'd51600;
   localparam logic [6:0]  PCT_DIV   = 7'd127;
   // Division by 100 as (x * 655) >> 16, again exact or one low.
   localparam logic [9:0]  HUND_RECIP = 10'd655;

   localparam logic [CFG_W-1:0] DEADZONE_RST = 7'd10;
   localparam logic [CFG_W-1:0] DUTY_MIN_RST = 7'd10;
   localparam logic [CFG_W-1:0] DUTY_MAX_RST = 7'd55;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX = 2'd2;

   typedef struct packed {
      logic                  capture;
      logic                  dev;
      logic                  pct;
      logic                  scale;
      logic                  duty;
      logic                  write;
      logic [AXIS_IDX_W-1:0] axis;
      logic [CH_W-1:0]       emit_idx;
   } cmd_type;

   typedef struct packed {
      logic clear_mode;
   } status_type;

   // Table index (channel number minus one) of the channel driven by
   // deflection below the stop band. Axes: 0 left_x, 1 left_y, 2 right_x, 3 right_y.
   function automatic logic [CH_W-1:0] low_chan(input logic lower,
                                                input logic [AXIS_IDX_W-1:0] axis);
      logic [CH_W-1:0] idx;
      case (axis)
         2'd0:    idx = lower ? 5'd13 : 5'd11;
         2'd1:    idx = lower ? 5'd19 : 5'd5;
         2'd2:    idx = lower ? 5'd15 : 5'd6;
         2'd3:    idx = lower ? 5'd17 : 5'd2;
         default: idx = 5'd0;
      endcase
      return idx;
   endfunction

   // Table index of the channel driven by deflection above the stop band.
   function automatic logic [CH_W-1:0] high_chan(input logic lower,
                                                 input logic [AXIS_IDX_W-1:0] axis);
      logic [CH_W-1:0] idx;
      case (axis)
         2'd0:    idx = lower ? 5'd12 : 5'd10;
         2'd1:    idx = lower ? 5'd18 : 5'd4;
         2'd2:    idx = lower ? 5'd14 : 5'd7;
         2'd3:    idx = lower ? 5'd16 : 5'd3;
         default: idx = 5'd0;
      endcase
      return idx;
   endfunction

endpackage

[sv/jvpm_ctrl.sv]
// Sequencer for the valve duty mapper: frame intake, per-axis steps and channel readout.
module jvpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  jvpm_pkg::status_type   status,
   output jvpm_pkg::cmd_type      cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DEV   = 7'b0000010,
      ST_PCT   = 7'b0000100,
      ST_SCALE = 7'b0001000,
      ST_DUTY  = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type                             state_ff, state_in;
   logic [jvpm_pkg::AXIS_IDX_W-1:0]       axis_ff, axis_in;
   logic [jvpm_pkg::CH_W-1:0]             emit_ff, emit_in;
   logic                                  accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      emit_in  = emit_ff;
      case (state_ff)
         ST_IDLE: begin
            axis_in = '0;
            emit_in = '0;
            if (accept) begin
               state_in = status.clear_mode ? ST_EMIT : ST_DEV;
            end
         end
         ST_DEV:   state_in = ST_PCT;
         ST_PCT:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DUTY;
         ST_DUTY:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (axis_ff == jvpm_pkg::LAST_AXIS) begin
               state_in = ST_EMIT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DEV;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (emit_ff == jvpm_pkg::LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         emit_ff  <= emit_in;
      end
   end

   always_comb begin
      cmd.capture  = accept;
      cmd.dev      = (state_ff == ST_DEV);
      cmd.pct      = (state_ff == ST_PCT);
      cmd.scale    = (state_ff == ST_SCALE);
      cmd.duty     = (state_ff == ST_DUTY);
      cmd.write    = (state_ff == ST_WRITE);
      cmd.axis     = axis_ff;
      cmd.emit_idx = emit_ff;
   end

endmodule

[sv/jvpm_datapath.sv]
// Datapath of the valve duty mapper: settings, frame hold, duty arithmetic and the duty table.
module jvpm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  jvpm_pkg::cmd_type                 cmd,
   output jvpm_pkg::status_type              status,
   input  logic [jvpm_pkg::REQ_W-1:0]        req_tdata,
   input  logic                              csr_write,
   input  logic [jvpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jvpm_pkg::CFG_W-1:0]        csr_wdata,
   output logic [jvpm_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                              rsp_tlast
);

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_LOW  = 2'd1,
      DIR_HIGH = 2'd2
   } dir_type;

   logic [jvpm_pkg::CFG_W-1:0]    deadzone_ff, duty_min_ff, duty_max_ff;
   logic [jvpm_pkg::STICK_W-1:0]  stick_ff [jvpm_pkg::NUM_AXES];
   logic                          lower_ff;
   logic [jvpm_pkg::DUTY_W-1:0]   duty_ff [jvpm_pkg::NUM_CH];

   logic [jvpm_pkg::STICK_W-1:0]  stick_v, lo_bound, hi_bound, defl_in;
   dir_type                       dir_in;
   logic [jvpm_pkg::STICK_W-1:0]  defl_ff;
   dir_type                       dir_ff;

   logic [23:0]                   prod1;
   logic [6:0]                    q0_ff;

   logic [13:0]                   pct_x, pct_r;
   logic [6:0]                    p_corr, p_sat, span;
   logic                          p_zero_ff;
   logic [13:0]                   prod2_ff;

   logic [23:0]                   prod3;
   logic [6:0]                    q1_ff;

   logic [13:0]                   hund_r;
   logic [7:0]                    q1_corr;
   logic [8:0]                    duty_sum;
   logic [jvpm_pkg::DUTY_W-1:0]   duty_val, low_val, high_val;
   logic [jvpm_pkg::CH_W-1:0]     low_idx, high_idx;

   logic                          mode_a, mode_b, motor_on;

   assign mode_a   = req_tdata[32];
   assign mode_b   = req_tdata[33];
   assign motor_on = req_tdata[34];
   assign status.clear_mode = mode_a;

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= jvpm_pkg::DEADZONE_RST;
         duty_min_ff <= jvpm_pkg::DUTY_MIN_RST;
         duty_max_ff <= jvpm_pkg::DUTY_MAX_RST;
      end else if (csr_write) begin
         case (csr_index)
            jvpm_pkg::CSR_DEADZONE: deadzone_ff <= csr_wdata;
            jvpm_pkg::CSR_DUTY_MIN: duty_min_ff <= csr_wdata;
            jvpm_pkg::CSR_DUTY_MAX: duty_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame hold.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < jvpm_pkg::NUM_AXES; i++) begin
            stick_ff[i] <= req_tdata[i*jvpm_pkg::STICK_W +: jvpm_pkg::STICK_W];
         end
         lower_ff <= mode_b;
      end
   end

   // Stop band test and deflection magnitude.
   always_comb begin
      stick_v  = stick_ff[cmd.axis];
      lo_bound = jvpm_pkg::STICK_MID - {1'b0, deadzone_ff};
      hi_bound = jvpm_pkg::STICK_MID + {1'b0, deadzone_ff};
      if (stick_v < lo_bound) begin
         dir_in  = DIR_LOW;
         defl_in = jvpm_pkg::STICK_MID - stick_v;
      end else if (stick_v > hi_bound) begin
         dir_in  = DIR_HIGH;
         defl_in = stick_v - jvpm_pkg::STICK_MID;
      end else begin
         dir_in  = DIR_NONE;
         defl_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dev) begin
         defl_ff <= defl_in;
         dir_ff  <= dir_in;
      end
   end

   // Percentage estimate by reciprocal multiplication.
   assign prod1 = 24'(defl_ff) * 24'(jvpm_pkg::PCT_SCALE);

   always_ff @(posedge clock) begin
      if (cmd.pct) begin
         q0_ff <= prod1[22:16];
      end
   end

   // Percentage correction, clamp and span product.
   always_comb begin
      pct_x  = 14'(defl_ff) * 14'(jvpm_pkg::FULL_PCT);
      pct_r  = pct_x - 14'(q0_ff) * 14'(jvpm_pkg::PCT_DIV);
      p_corr = (pct_r >= 14'(jvpm_pkg::PCT_DIV)) ? q0_ff + 1'b1 : q0_ff;
      p_sat  = (p_corr > jvpm_pkg::FULL_PCT) ? jvpm_pkg::FULL_PCT : p_corr;
      span   = (duty_max_ff >= duty_min_ff) ? duty_max_ff - duty_min_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         p_zero_ff <= (p_sat == '0);
         prod2_ff  <= 14'(p_sat) * 14'(span);
      end
   end

   // Division of the span product by 100.
   assign prod3 = 24'(prod2_ff) * 24'(jvpm_pkg::HUND_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.duty) begin
         q1_ff <= prod3[22:16];
      end
   end

   // Quotient correction, offset by the minimum duty and saturation.
   always_comb begin
      hund_r   = prod2_ff - 14'(q1_ff) * 14'(jvpm_pkg::FULL_PCT);
      q1_corr  = (hund_r >= 14'(jvpm_pkg::FULL_PCT)) ? {1'b0, q1_ff} + 8'd1 : {1'b0, q1_ff};
      duty_sum = {2'b00, duty_min_ff} + {1'b0, q1_corr};
      if (p_zero_ff) begin
         duty_val = '0;
      end else if (duty_sum > 9'(jvpm_pkg::FULL_PCT)) begin
         duty_val = jvpm_pkg::FULL_PCT;
      end else begin
         duty_val = duty_sum[6:0];
      end
      low_idx  = jvpm_pkg::low_chan(lower_ff, cmd.axis);
      high_idx = jvpm_pkg::high_chan(lower_ff, cmd.axis);
      low_val  = (dir_ff == DIR_LOW)  ? duty_val : '0;
      high_val = (dir_ff == DIR_HIGH) ? duty_val : '0;
   end

   // Duty table.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < jvpm_pkg::NUM_CH; i++) begin
            duty_ff[i] <= '0;
         end
      end else if (cmd.capture) begin
         for (int i = 0; i < jvpm_pkg::NUM_CH - 1; i++) begin
            if (mode_a) begin
               duty_ff[i] <= '0;
            end else if (!mode_b) begin
               if (i >= 12) begin
                  duty_ff[i] <= '0;
               end
            end else if (i <= 5 || i == 10 || i == 11) begin
               duty_ff[i] <= '0;
            end
         end
         duty_ff[jvpm_pkg::NUM_CH-1] <= motor_on ? jvpm_pkg::FULL_PCT : '0;
      end else if (cmd.write) begin
         for (int i = 0; i < jvpm_pkg::NUM_CH; i++) begin
            if (low_idx == i[jvpm_pkg::CH_W-1:0]) begin
               duty_ff[i] <= low_val;
            end
            if (high_idx == i[jvpm_pkg::CH_W-1:0]) begin
               duty_ff[i] <= high_val;
            end
         end
      end
   end

   // Readout word: channel number in the low bits, duty above it.
   always_comb begin
      rsp_tdata = {4'b0000, duty_ff[cmd.emit_idx], cmd.emit_idx + 5'd1};
      rsp_tlast = (cmd.emit_idx == jvpm_pkg::LAST_IDX);
   end

endmodule

[sv/joystick_to_valve_pwm_mapper_core.sv]
// Top level of the joystick frame to valve duty mapper: sequencer plus datapath.
//
//   Channel  Direction  Handshake                 Carries
//   req      in         req_tvalid / req_tready   one control frame per word
//   rsp      out        rsp_tvalid / rsp_tready   one channel duty per word
//   csr      in         csr_valid / csr_ready     settings register writes
//
// A frame in upper or lower mode passes through the shared duty arithmetic
// once for each of the four stick axes, in the steps deviation, percentage,
// scale, duty and table write; the 21 channel words then leave at one per
// cycle while rsp_tready is high. The clearing mode skips the arithmetic and
// goes straight to the channel words.
// Reset is synchronous and restores the settings defaults and clears all
// channel duties. A stall on the result side holds the current word and
// keeps req_tready low until the last channel word has been taken.
module joystick_to_valve_pwm_mapper_core (
   input  logic                              clock,
   input  logic                              reset,
   // left_x [7:0], left_y [15:8], right_x [23:16], right_y [31:24],
   // mode_a [32], mode_b [33], motor_on [34], zero fill [39:35]
   input  logic [jvpm_pkg::REQ_W-1:0]        req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // channel [4:0], duty [11:5], zero fill [15:12]
   output logic [jvpm_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [jvpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jvpm_pkg::CFG_W-1:0]        csr_wdata
);

   jvpm_pkg::cmd_type    cmd;
   jvpm_pkg::status_type status;

   // Settings writes are always taken; the user must issue them only while idle, as the block does not enforce it.
   assign csr_ready = 1'b1;

   jvpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jvpm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
